### rtl/itaf_pkg.sv
// Package for the integer-to-ASCII formatter.
// Holds the op codes, the command passed from the front to the back,
// the character constants and the decimal digit step. It has no dependencies.
package itaf_pkg;

  // Conversion kinds as carried by the op field of an input item.
  typedef enum logic [2:0] {
    OP_LIT  = 3'd0,
    OP_SDEC = 3'd1,
    OP_OCT  = 3'd2,
    OP_UDEC = 3'd3,
    OP_HEXU = 3'd4,
    OP_CHAR = 3'd5,
    OP_PTR  = 3'd6,
    OP_UNK  = 3'd7
  } op_t;

  // Radix and letter case used by the digit sequencer.
  typedef enum logic [1:0] {
    K_DEC  = 2'd0,
    K_OCT  = 2'd1,
    K_HEXU = 2'd2,
    K_HEXL = 2'd3
  } kind_t;

  // States of the back-end sequencer.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PRE  = 2'd1,
    BK_NUM  = 2'd2
  } back_state_t;

  // One classified item: up to two prefix characters, then an optional number.
  // For octal and hex the number is left aligned so the next digit is on top.
  typedef struct packed {
    logic [1:0]  pre_cnt;
    logic [7:0]  pre0;
    logic [7:0]  pre1;
    logic        has_num;
    kind_t       kind;
    logic [63:0] num;
    logic [3:0]  top_pos;
  } cmd_t;

  // Result of one decimal digit step.
  typedef struct packed {
    logic [3:0]  digit;
    logic [31:0] rem;
  } dec_step_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  localparam int          DEC_POS  = 10;
  localparam logic [3:0]  DEC_TOP  = 4'd9;
  localparam logic [3:0]  OCT_TOP  = 4'd10;
  localparam logic [3:0]  HEX32_TOP = 4'd7;
  localparam logic [3:0]  HEX64_TOP = 4'd15;

  localparam logic [35:0] POW10 [DEC_POS] = '{
    36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
    36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
  };

  // Finds the decimal digit at position pos by comparing the remainder
  // against all nine multiples of that power of ten in parallel.
  function automatic dec_step_t dec_step(input logic [31:0] rem, input logic [3:0] pos);
    dec_step_t  res;
    logic [3:0] idx;
    logic [35:0] sub;
    logic [35:0] mult;
    idx = (pos > DEC_TOP) ? 4'd0 : pos;
    res.digit = 4'd0;
    sub = 36'd0;
    for (int k = 1; k < 10; k++) begin
      mult = 36'(k) * POW10[idx];
      if ({4'd0, rem} >= mult) begin
        res.digit = 4'(k);
        sub = mult;
      end
    end
    res.rem = rem - sub[31:0];
    return res;
  endfunction

  // Turns a digit value into its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [7:0] letter);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = letter + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### rtl/itaf_front.sv
// Front end of the integer-to-ASCII formatter: accepts items, classifies
// them into prefix characters and a number to convert, and queues the result.
// Depends on itaf_pkg.
module itaf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      op,
  input  logic [63:0]     value,
  output logic            cmd_valid,
  output itaf_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);
  import itaf_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic [31:0] w;
  logic [31:0] mag;
  logic       wr_en;
  logic       rd_en;

  // Classify the incoming item.
  always_comb begin
    w = value[31:0];
    mag = w;
    cls.pre_cnt = 2'd0;
    cls.pre0 = 8'd0;
    cls.pre1 = 8'd0;
    cls.has_num = 1'b0;
    cls.kind = K_DEC;
    cls.num = 64'd0;
    cls.top_pos = 4'd0;
    case (op_t'(op))
      OP_LIT, OP_CHAR: begin
        cls.pre_cnt = 2'd1;
        cls.pre0 = value[7:0];
      end
      OP_SDEC: begin
        if (w[31]) begin
          cls.pre_cnt = 2'd1;
          cls.pre0 = CH_MINUS;
          mag = ~w + 32'd1;
        end
        cls.has_num = 1'b1;
        cls.num = {32'd0, mag};
        cls.top_pos = DEC_TOP;
      end
      OP_UDEC: begin
        cls.has_num = 1'b1;
        cls.num = {32'd0, w};
        cls.top_pos = DEC_TOP;
      end
      OP_OCT: begin
        cls.has_num = 1'b1;
        cls.kind = K_OCT;
        cls.num = {1'b0, w, 31'd0};
        cls.top_pos = OCT_TOP;
      end
      OP_HEXU: begin
        cls.has_num = 1'b1;
        cls.kind = K_HEXU;
        cls.num = {w, 32'd0};
        cls.top_pos = HEX32_TOP;
      end
      OP_PTR: begin
        cls.pre_cnt = 2'd2;
        cls.pre0 = CH_ZERO;
        cls.pre1 = CH_X;
        cls.has_num = 1'b1;
        cls.kind = K_HEXL;
        cls.num = value;
        cls.top_pos = HEX64_TOP;
      end
      default: begin
        cls.pre_cnt = 2'd2;
        cls.pre0 = CH_PCT;
        cls.pre1 = value[7:0];
      end
    endcase
  end

  // Two-entry command queue between front and back.
  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];
  assign wr_en = push && !full;
  assign rd_en = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) begin
        wp <= ~wp;
      end
      if (rd_en) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wp] <= cls;
    end
  end

endmodule

### rtl/itaf_back.sv
// Back end of the integer-to-ASCII formatter: walks the prefix characters and
// the digit positions of one command and feeds a two-entry output queue.
// Depends on itaf_pkg.
module itaf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  itaf_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      char_out,
  output logic            last
);
  import itaf_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [1:0]  pre_cnt;
  logic [7:0]  pre0;
  logic [7:0]  pre1;
  logic        has_num;
  kind_t       kind;
  logic [63:0] num;
  logic [3:0]  pos;
  logic        started;

  logic [7:0]  oq_char [2];
  logic        oq_last [2];
  logic        owp;
  logic        orp;
  logic [1:0]  ocnt;
  logic        oq_room;
  logic        wr_en;
  logic [7:0]  wr_char;
  logic        wr_last;
  logic        rd_en;

  dec_step_t   dstep;
  logic [3:0]  digit;
  logic [7:0]  letter;
  logic        emit_num;
  logic        load;
  logic        pre_step;
  logic        num_step;

  // Digit at the current position for the active radix.
  always_comb begin
    dstep = dec_step(num[31:0], pos);
    letter = (kind == K_HEXL) ? CH_LA : CH_UA;
    case (kind)
      K_DEC:         digit = dstep.digit;
      K_OCT:         digit = {1'b0, num[63:61]};
      K_HEXU, K_HEXL: digit = num[63:60];
      default:       digit = 4'd0;
    endcase
    emit_num = (digit != 4'd0) || started || (pos == 4'd0);
  end

  // Sequencer next state and queue write.
  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    load = 1'b0;
    pre_step = 1'b0;
    num_step = 1'b0;
    wr_en = 1'b0;
    wr_char = pre0;
    wr_last = 1'b0;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          load = 1'b1;
          state_next = (cmd.pre_cnt != 2'd0) ? BK_PRE : BK_NUM;
        end
      end
      BK_PRE: begin
        if (oq_room) begin
          pre_step = 1'b1;
          wr_en = 1'b1;
          wr_char = pre0;
          wr_last = (pre_cnt == 2'd1) && !has_num;
          if (pre_cnt == 2'd1) begin
            state_next = has_num ? BK_NUM : BK_IDLE;
          end
        end
      end
      BK_NUM: begin
        if (!emit_num || oq_room) begin
          num_step = 1'b1;
          wr_en = emit_num;
          wr_char = digit_char(digit, letter);
          wr_last = (pos == 4'd0);
          if (pos == 4'd0) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the command in progress.
  always_ff @(posedge clk) begin
    if (load) begin
      pre_cnt <= cmd.pre_cnt;
      pre0 <= cmd.pre0;
      pre1 <= cmd.pre1;
      has_num <= cmd.has_num;
      kind <= cmd.kind;
      num <= cmd.num;
      pos <= cmd.top_pos;
      started <= 1'b0;
    end else if (pre_step) begin
      pre0 <= pre1;
      pre_cnt <= pre_cnt - 2'd1;
    end else if (num_step) begin
      if (emit_num) begin
        started <= 1'b1;
      end
      pos <= pos - 4'd1;
      case (kind)
        K_DEC:   num <= {32'd0, dstep.rem};
        K_OCT:   num <= {num[60:0], 3'd0};
        default: num <= {num[59:0], 4'd0};
      endcase
    end
  end

  // Two-entry output queue that decouples the sequencer from the receiver.
  assign oq_room = (ocnt != 2'd2);
  assign empty = (ocnt == 2'd0);
  assign rd_en = pop && !empty;
  assign char_out = oq_char[orp];
  assign last = oq_last[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= 1'b0;
      orp <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (wr_en) begin
        owp <= ~owp;
      end
      if (rd_en) begin
        orp <= ~orp;
      end
      ocnt <= ocnt + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      oq_char[owp] <= wr_char;
      oq_last[owp] <= wr_last;
    end
  end

endmodule

### rtl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter.
// Instantiates itaf_front and itaf_back; depends on itaf_pkg.
//
// Usage: both sides look like a queue. An item (op, value) is accepted on a
// rising edge with push high and full low. Its characters come out most
// significant first on char_out, with last set on the final one; a character
// is taken on a rising edge with pop high and empty low.
// The front classifies each item into prefix characters and a number and
// queues it (two entries). The back walks one digit position per cycle unless
// a digit waits for room in the full output queue: 10 positions for decimal,
// 11 for octal, 8 for hex, 16 for a pointer. Leading zero positions are
// stepped over without output. For each item the back loads the command, then
// writes each prefix character, then steps through each digit position.
// The first character passes through the command queue, the working
// registers and the output queue, and skipped zeros delay it further.
// Reset clears both queues and the sequencer; any item in flight is dropped.
// When the receiver stalls, the two-entry output queue fills, the sequencer
// holds, and the command queue then fills and raises full.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [63:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_out,
  output logic        last
);
  import itaf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  itaf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  itaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .char_out  (char_out),
    .last      (last)
  );

  // The back only takes a command that the front is offering.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  // Reset leaves no character waiting.
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for a new item.
  a_rst_full: assert property (@(posedge clk) $past(rst) |-> !full)
    else $error("command queue full after reset");

endmodule

### dv/itaf_text_checker.sv
// Checker for the integer-to-ASCII formatter: watches the item and character
// channels, works out the expected text and compares each character taken.
// Depends on itaf_pkg for the op codes and character constants.
module itaf_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  op,
  input  logic [63:0] value,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  char_out,
  input  logic        last,
  output int          errors,
  output int          outstanding
);
  import itaf_pkg::*;

  localparam int MAX_CHARS = 18;
  localparam int MAX_REPORTS = 10;

  // One expected character and whether it ends its item.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  text_char_t expected_text[$];

  // Scratch line that holds the text of the item being predicted.
  logic [7:0] line_buf [0:MAX_CHARS-1];
  int         line_len;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic add_char(input logic [7:0] c);
    line_buf[line_len] = c;
    line_len++;
  endtask

  // Appends mag in the given radix, most significant digit first.
  task automatic add_number(input logic [63:0] mag, input logic [63:0] radix,
                            input logic [7:0] letter);
    logic [7:0]  rev [0:23];
    logic [63:0] rest;
    logic [63:0] d;
    int          cnt;
    cnt = 0;
    rest = mag;
    if (rest == 64'd0) begin
      add_char(CH_ZERO);
    end
    while (rest != 64'd0) begin
      d = rest % radix;
      rev[cnt] = (d < 64'd10) ? CH_ZERO + d[7:0] : letter + d[7:0] - 8'd10;
      cnt++;
      rest = rest / radix;
    end
    while (cnt > 0) begin
      cnt--;
      add_char(rev[cnt]);
    end
  endtask

  // Works out the text of one item and queues its characters.
  task automatic format_item(input op_t kind, input logic [63:0] arg);
    logic [31:0] word;
    line_len = 0;
    word = arg[31:0];
    case (kind)
      OP_LIT, OP_CHAR: begin
        add_char(arg[7:0]);
      end
      OP_SDEC: begin
        // The most negative value negates to itself, which is its magnitude.
        if (word[31]) begin
          add_char(CH_MINUS);
          word = -word;
        end
        add_number({32'd0, word}, 64'd10, CH_UA);
      end
      OP_OCT: begin
        add_number({32'd0, word}, 64'd8, CH_UA);
      end
      OP_UDEC: begin
        add_number({32'd0, word}, 64'd10, CH_UA);
      end
      OP_HEXU: begin
        add_number({32'd0, word}, 64'd16, CH_UA);
      end
      OP_PTR: begin
        add_char(CH_ZERO);
        add_char(CH_X);
        add_number(arg, 64'd16, CH_LA);
      end
      default: begin
        add_char(CH_PCT);
        add_char(arg[7:0]);
      end
    endcase
    for (int i = 0; i < line_len; i++) begin
      expected_text.push_back('{ch: line_buf[i], fin: (i == line_len - 1)});
    end
  endtask

  // Compare characters taken, then predict the text of items accepted.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("unexpected character: char_out=%h last=%b", char_out, last);
          end
        end else begin
          want = expected_text.pop_front();
          if (char_out !== want.ch || last !== want.fin) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch: expected char_out=%h last=%b, got char_out=%h last=%b",
                       want.ch, want.fin, char_out, last);
            end
          end
        end
      end
      if (push && !full) begin
        format_item(op_t'(op), value);
      end
    end
    outstanding <= expected_text.size();
  end

endmodule

### dv/tb.sv
// Top of the formatter testbench: clock, reset, item stimulus, receiver
// stalls, watchdog and verdict. Depends on itaf_pkg, the formatter RTL and
// itaf_text_checker.
module tb;
  import itaf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 40;
  localparam int SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [2:0]  op = OP_LIT;
  logic [63:0] value = 64'd0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  char_out;
  logic        last;
  int          errors;
  int          outstanding;

  // Idle and stall odds in percent, and a request for one long receiver hold.
  int          tx_idle = 0;
  int          rx_stall = 0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  integer_to_ascii_formatter DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .value(value),
    .empty(empty), .pop(pop), .char_out(char_out), .last(last)
  );

  itaf_text_checker text_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .value(value),
    .empty(empty), .pop(pop), .char_out(char_out), .last(last),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold counted here when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  // The run ends if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_item(input op_t kind, input logic [63:0] arg);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= kind;
    value <= arg;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
  endtask

  // Stops offering items until every expected character has been taken.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // Values that favor boundaries of the 32-bit and 64-bit forms.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = {$urandom, 32'h8000_0000};
      1: v = {$urandom, 32'($urandom_range(20))};
      2: v = {$urandom, 32'h7FFF_FFFF ^ 32'($urandom_range(1))};
      3: v = {32'd0, $urandom};
      4: v = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic run_phase(input int tx, input int rx, input bit long_hold);
    tx_idle = tx;
    rx_stall = rx;
    if (long_hold) begin
      hold_req = 1'b1;
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_item(op_t'($urandom_range(7)), pick_value());
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items: zero for each kind, extremes, and ignored upper bits.
    send_item(OP_LIT, 64'h0);
    send_item(OP_LIT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_SDEC, 64'h0);
    send_item(OP_SDEC, 64'h0000_0000_8000_0000);
    send_item(OP_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
    send_item(OP_SDEC, 64'h1234_5678_FFFF_FFFF);
    send_item(OP_OCT, 64'h0);
    send_item(OP_OCT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_UDEC, 64'h0);
    send_item(OP_UDEC, 64'hDEAD_BEEF_FFFF_FFFF);
    send_item(OP_HEXU, 64'h0);
    send_item(OP_HEXU, 64'hFFFF_FFFF_ABCD_EF01);
    send_item(OP_CHAR, 64'h0);
    send_item(OP_CHAR, 64'hFFFF_FFFF_FFFF_FF41);
    send_item(OP_PTR, 64'h0);
    send_item(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_PTR, 64'h0123_4567_89AB_CDEF);
    send_item(OP_PTR, 64'h0000_0000_0000_000F);
    send_item(OP_UNK, 64'h0);
    send_item(OP_UNK, 64'hFFFF_FFFF_FFFF_FF64);
    drain();

    // Random phases with different idle patterns, then a long receiver hold.
    run_phase(0, 0, 1'b0);
    run_phase(71, 0, 1'b0);
    run_phase(0, 71, 1'b0);
    run_phase(7, 7, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/itaf_pkg.sv
rtl/itaf_front.sv
rtl/itaf_back.sv
rtl/integer_to_ascii_formatter.sv
dv/itaf_text_checker.sv
dv/tb.sv
